// File: rtl/lcd4_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcd4_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // request codes carried on func
    typedef enum logic [2:0] {
        FUNC_TICK   = 3'd0,
        FUNC_CMD    = 3'd1,
        FUNC_DATA   = 3'd2,
        FUNC_CURSOR = 3'd3,
        FUNC_CLEAR  = 3'd4,
        FUNC_INIT   = 3'd5
    } func_t;

    // register indexes, byte address is 4 * index
    localparam logic [2:0] REG_SHORT_DELAY = 3'd0;
    localparam logic [2:0] REG_LONG_DELAY  = 3'd1;
    localparam logic [2:0] REG_POWER_UP    = 3'd2;
    localparam logic [2:0] REG_INIT_FUNC   = 3'd3;
    localparam logic [2:0] REG_INIT_DISP   = 3'd4;
    localparam logic [2:0] REG_INIT_ENTRY  = 3'd5;

    localparam logic [15:0] RST_SHORT_DELAY = 16'd100;
    localparam logic [15:0] RST_LONG_DELAY  = 16'd2000;
    localparam logic [15:0] RST_POWER_UP    = 16'd15000;
    localparam logic [7:0]  RST_INIT_FUNC   = 8'h28;
    localparam logic [7:0]  RST_INIT_DISP   = 8'h0C;
    localparam logic [7:0]  RST_INIT_ENTRY  = 8'h06;

    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] ROW_OFFSET    = 8'h40;
    localparam logic [3:0] NIB_WAKE      = 4'h3;
    localparam logic [3:0] NIB_4BIT      = 4'h2;

    // init sequence steps
    localparam logic [3:0] STEP_NONE     = 4'd0;
    localparam logic [3:0] STEP_FIRST    = 4'd1;
    localparam logic [3:0] STEP_LAST_NIB = 4'd4;
    localparam logic [3:0] STEP_FUNC     = 4'd5;
    localparam logic [3:0] STEP_DISP     = 4'd6;
    localparam logic [3:0] STEP_ENTRY    = 4'd7;
    localparam logic [3:0] STEP_CLEAR    = 4'd8;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_PWR_WAIT = 4'd1,
        PH_NIB_EN   = 4'd2,
        PH_NIB_FALL = 4'd3,
        PH_HI_EN    = 4'd4,
        PH_HI_FALL  = 4'd5,
        PH_LO_EN    = 4'd6,
        PH_LO_FALL  = 4'd7,
        PH_WAIT_S   = 4'd8,
        PH_WAIT_L   = 4'd9
    } phase_t;

    typedef struct packed {
        logic [15:0] short_delay_ticks;
        logic [15:0] long_delay_ticks;
        logic [15:0] power_up_ticks;
        logic [7:0]  init_function_word;
        logic [7:0]  init_display_word;
        logic [7:0]  init_entry_word;
    } cfg_t;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] value;
        logic [5:0] col;
        logic       row;
    } req_t;

    typedef struct packed {
        logic       rs;
        logic       en;
        logic [3:0] nibble;
        logic       busy_res;
        logic       refused;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/lcd4_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module lcd4_cfg_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [lcd4_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [lcd4_pkg::DATA_W-1:0]  pwdata,
    output logic      [lcd4_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    output lcd4_pkg::cfg_t                    cfg
);
    import lcd4_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_delay_ticks  <= RST_SHORT_DELAY;
            cfg_reg.long_delay_ticks   <= RST_LONG_DELAY;
            cfg_reg.power_up_ticks     <= RST_POWER_UP;
            cfg_reg.init_function_word <= RST_INIT_FUNC;
            cfg_reg.init_display_word  <= RST_INIT_DISP;
            cfg_reg.init_entry_word    <= RST_INIT_ENTRY;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SHORT_DELAY: cfg_reg.short_delay_ticks  <= pwdata[15:0];
                REG_LONG_DELAY:  cfg_reg.long_delay_ticks   <= pwdata[15:0];
                REG_POWER_UP:    cfg_reg.power_up_ticks     <= pwdata[15:0];
                REG_INIT_FUNC:   cfg_reg.init_function_word <= pwdata[7:0];
                REG_INIT_DISP:   cfg_reg.init_display_word  <= pwdata[7:0];
                REG_INIT_ENTRY:  cfg_reg.init_entry_word    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_SHORT_DELAY: prdata = {16'd0, cfg_reg.short_delay_ticks};
            REG_LONG_DELAY:  prdata = {16'd0, cfg_reg.long_delay_ticks};
            REG_POWER_UP:    prdata = {16'd0, cfg_reg.power_up_ticks};
            REG_INIT_FUNC:   prdata = {24'd0, cfg_reg.init_function_word};
            REG_INIT_DISP:   prdata = {24'd0, cfg_reg.init_display_word};
            REG_INIT_ENTRY:  prdata = {24'd0, cfg_reg.init_entry_word};
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/lcd4_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module lcd4_seq (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire lcd4_pkg::cfg_t   cfg,
    input  wire logic             step_en,
    input  wire lcd4_pkg::req_t   req,
    output lcd4_pkg::res_t        res
);
    import lcd4_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] wait_count_reg, wait_count_next;
    logic [7:0]  byte_hold_reg, byte_hold_next;
    logic [3:0]  init_step_reg, init_step_next;
    logic        rs_reg, rs_next;
    logic        en_reg, en_next;
    logic [3:0]  nib_reg, nib_next;
    logic        clear_pending_reg, clear_pending_next;
    logic        refused;

    logic        is_req;
    logic        wait_done;
    logic [15:0] wait_dec;
    logic [7:0]  cursor_byte;

    // what follows a finished byte or nibble
    logic        na_in_init;
    logic [3:0]  na_step;
    logic [7:0]  na_byte;

    assign is_req      = (req.func >= FUNC_CMD) && (req.func <= FUNC_INIT);
    assign wait_done   = (wait_count_reg <= 16'd1);
    assign wait_dec    = wait_done ? 16'd0 : wait_count_reg - 16'd1;
    assign cursor_byte = ({2'b00, req.col} + (req.row ? ROW_OFFSET : 8'd0)) | CMD_SET_DDRAM;
    assign na_in_init  = (init_step_reg >= STEP_FIRST) && (init_step_reg <= STEP_ENTRY);
    assign na_step     = init_step_reg + 4'd1;

    always_comb begin
        case (na_step)
            STEP_FUNC:  na_byte = cfg.init_function_word;
            STEP_DISP:  na_byte = cfg.init_display_word;
            STEP_ENTRY: na_byte = cfg.init_entry_word;
            default:    na_byte = CMD_CLEAR;
        endcase
    end

    // next state
    always_comb begin
        phase_next         = phase_reg;
        wait_count_next    = wait_count_reg;
        byte_hold_next     = byte_hold_reg;
        init_step_next     = init_step_reg;
        rs_next            = rs_reg;
        en_next            = en_reg;
        nib_next           = nib_reg;
        clear_pending_next = clear_pending_reg;
        refused            = 1'b0;

        if (is_req && phase_reg == PH_IDLE) begin
            // byte requests raise EN with the high nibble right away
            init_step_next     = STEP_NONE;
            clear_pending_next = 1'b0;
            rs_next            = 1'b0;
            en_next            = 1'b1;
            phase_next         = PH_HI_FALL;
            unique case (func_t'(req.func))
                FUNC_CMD: begin
                    byte_hold_next = req.value;
                    nib_next       = req.value[7:4];
                end
                FUNC_DATA: begin
                    byte_hold_next = req.value;
                    nib_next       = req.value[7:4];
                    rs_next        = 1'b1;
                end
                FUNC_CURSOR: begin
                    byte_hold_next = cursor_byte;
                    nib_next       = cursor_byte[7:4];
                end
                FUNC_CLEAR: begin
                    byte_hold_next     = CMD_CLEAR;
                    nib_next           = CMD_CLEAR[7:4];
                    clear_pending_next = 1'b1;
                end
                default: begin
                    en_next         = 1'b0;
                    init_step_next  = STEP_FIRST;
                    wait_count_next = cfg.power_up_ticks;
                    phase_next      = PH_PWR_WAIT;
                end
            endcase
        end else begin
            refused = is_req;
            unique case (phase_reg)
                PH_PWR_WAIT: begin
                    wait_count_next = wait_dec;
                    if (wait_done) phase_next = PH_NIB_EN;
                end
                PH_NIB_EN: begin
                    en_next    = 1'b1;
                    nib_next   = (init_step_reg == STEP_LAST_NIB) ? NIB_4BIT : NIB_WAKE;
                    phase_next = PH_NIB_FALL;
                end
                PH_NIB_FALL, PH_LO_FALL: begin
                    en_next         = 1'b0;
                    wait_count_next = cfg.short_delay_ticks;
                    phase_next      = PH_WAIT_S;
                end
                PH_HI_EN: begin
                    en_next    = 1'b1;
                    nib_next   = byte_hold_reg[7:4];
                    phase_next = PH_HI_FALL;
                end
                PH_HI_FALL: begin
                    en_next    = 1'b0;
                    phase_next = PH_LO_EN;
                end
                PH_LO_EN: begin
                    en_next    = 1'b1;
                    nib_next   = byte_hold_reg[3:0];
                    phase_next = PH_LO_FALL;
                end
                PH_WAIT_S, PH_WAIT_L: begin
                    wait_count_next = wait_dec;
                    if (wait_done) begin
                        if (phase_reg == PH_WAIT_S && clear_pending_reg) begin
                            wait_count_next = cfg.long_delay_ticks;
                            phase_next      = PH_WAIT_L;
                        end else begin
                            clear_pending_next = 1'b0;
                            if (na_in_init) begin
                                init_step_next = na_step;
                                if (na_step <= STEP_LAST_NIB) begin
                                    phase_next = PH_NIB_EN;
                                end else begin
                                    byte_hold_next     = na_byte;
                                    clear_pending_next = (na_step == STEP_CLEAR);
                                    rs_next            = 1'b0;
                                    phase_next         = PH_HI_EN;
                                end
                            end else begin
                                init_step_next = STEP_NONE;
                                phase_next     = PH_IDLE;
                            end
                        end
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // result word, pin levels after this step
    always_comb begin
        res.rs       = rs_next;
        res.en       = en_next;
        res.nibble   = nib_next;
        res.busy_res = (phase_next != PH_IDLE);
        res.refused  = refused;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            wait_count_reg    <= '0;
            byte_hold_reg     <= '0;
            init_step_reg     <= STEP_NONE;
            rs_reg            <= 1'b0;
            en_reg            <= 1'b0;
            nib_reg           <= '0;
            clear_pending_reg <= 1'b0;
        end else if (step_en) begin
            phase_reg         <= phase_next;
            wait_count_reg    <= wait_count_next;
            byte_hold_reg     <= byte_hold_next;
            init_step_reg     <= init_step_next;
            rs_reg            <= rs_next;
            en_reg            <= en_next;
            nib_reg           <= nib_next;
            clear_pending_reg <= clear_pending_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/char_lcd_4bit_interface_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Character LCD pin sequencer for a 4-bit HD44780-style bus. Every input word
// (a tick or a request) advances the sequencer by one step and yields one
// result word with the RS, EN and D4..D7 levels, busy and refused flags.
// Requests (command, data, set cursor, clear, init) are taken only when idle;
// a request while busy is dropped and flagged. Delays are counted in input
// words and set through the APB registers, which the user must write only
// while idle; the block does not enforce this. Throughput is one word per
// cycle unless the output stalls: input register, sequencer, result register.
module char_lcd_4bit_interface_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [2:0]                   s_func,
    input  wire logic [7:0]                   s_value,
    input  wire logic [5:0]                   s_col,
    input  wire logic                         s_row,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_rs,
    output logic                              m_en,
    output logic [3:0]                        m_nibble,
    output logic                              m_busy_res,
    output logic                              m_refused,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [lcd4_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [lcd4_pkg::DATA_W-1:0]  pwdata,
    output logic      [lcd4_pkg::DATA_W-1:0]  prdata,
    output logic                              pready
);
    import lcd4_pkg::*;

    cfg_t cfg;
    req_t in_req_reg;
    logic in_valid_reg;
    res_t step_res;
    res_t out_res_reg;
    logic out_valid_reg;
    logic step_en;

    lcd4_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // step when a word is held and the result slot is free or draining
    assign step_en = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step_en;

    lcd4_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step_en (step_en),
        .req     (in_req_reg),
        .res     (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            if (step_en) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg.func  <= s_func;
            in_req_reg.value <= s_value;
            in_req_reg.col   <= s_col;
            in_req_reg.row   <= s_row;
        end
        if (step_en) out_res_reg <= step_res;
    end

    assign m_valid    = out_valid_reg;
    assign m_rs       = out_res_reg.rs;
    assign m_en       = out_res_reg.en;
    assign m_nibble   = out_res_reg.nibble;
    assign m_busy_res = out_res_reg.busy_res;
    assign m_refused  = out_res_reg.refused;

endmodule

`default_nettype wire

// File: tb/sv/char_lcd_4bit_interface_unit_tb.sv
`timescale 1ns / 1ps

module char_lcd_4bit_interface_unit_tb;

    import lcd4_pkg::*;

    localparam int LATENCY        = 2;
    localparam int WATCHDOG_LIMIT = 2000;

    // func codes the block treats as a plain tick
    localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

    class lcd_pin_scoreboard;
        cfg_t        cfg;
        phase_t      ph;
        logic [15:0] wait_cnt;
        logic [7:0]  hold;
        logic [3:0]  step;
        logic [5:0]  pins;      // [3:0] nibble, [4] rs, [5] en
        bit          clr_pend;
        res_t        pin_levels_q[$];
        int          mismatches;

        function new();
            cfg.short_delay_ticks  = RST_SHORT_DELAY;
            cfg.long_delay_ticks   = RST_LONG_DELAY;
            cfg.power_up_ticks     = RST_POWER_UP;
            cfg.init_function_word = RST_INIT_FUNC;
            cfg.init_display_word  = RST_INIT_DISP;
            cfg.init_entry_word    = RST_INIT_ENTRY;
            ph         = PH_IDLE;
            wait_cnt   = '0;
            hold       = '0;
            step       = STEP_NONE;
            pins       = '0;
            clr_pend   = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] v);
            case (idx)
                REG_SHORT_DELAY: cfg.short_delay_ticks  = v;
                REG_LONG_DELAY:  cfg.long_delay_ticks   = v;
                REG_POWER_UP:    cfg.power_up_ticks     = v;
                REG_INIT_FUNC:   cfg.init_function_word = v[7:0];
                REG_INIT_DISP:   cfg.init_display_word  = v[7:0];
                REG_INIT_ENTRY:  cfg.init_entry_word    = v[7:0];
                default: ;
            endcase
        endfunction

        function bit seq_busy();
            return ph != PH_IDLE;
        endfunction

        // zero and one both end the wait on this tick
        function bit count_down();
            if (wait_cnt <= 16'd1) begin
                wait_cnt = '0;
                return 1'b1;
            end
            wait_cnt = wait_cnt - 16'd1;
            return 1'b0;
        endfunction

        function void load_byte(logic [7:0] b, bit rs, bit clr);
            hold      = b;
            clr_pend  = clr;
            step      = STEP_NONE;
            pins[4]   = rs;
            pins[5]   = 1'b1;
            pins[3:0] = b[7:4];
            ph        = PH_HI_FALL;
        endfunction

        function void next_step();
            if (step >= STEP_FIRST && step <= STEP_ENTRY) begin
                step = step + 4'd1;
                if (step <= STEP_LAST_NIB) begin
                    ph = PH_NIB_EN;
                end else begin
                    case (step)
                        STEP_FUNC:  hold = cfg.init_function_word;
                        STEP_DISP:  hold = cfg.init_display_word;
                        STEP_ENTRY: hold = cfg.init_entry_word;
                        default:    hold = CMD_CLEAR;
                    endcase
                    clr_pend = (step == STEP_CLEAR);
                    pins[4]  = 1'b0;
                    ph       = PH_HI_EN;
                end
            end else begin
                step = STEP_NONE;
                ph   = PH_IDLE;
            end
        endfunction

        function void note_word(req_t r);
            res_t       want;
            logic [7:0] cursor;
            bit         is_req;
            bit         dropped;
            is_req  = (r.func >= FUNC_CMD) && (r.func <= FUNC_INIT);
            dropped = 1'b0;
            if (is_req && ph == PH_IDLE) begin
                case (r.func)
                    FUNC_CMD:  load_byte(r.value, 1'b0, 1'b0);
                    FUNC_DATA: load_byte(r.value, 1'b1, 1'b0);
                    FUNC_CURSOR: begin
                        cursor = ({2'b00, r.col} + (r.row ? ROW_OFFSET : 8'h00)) | CMD_SET_DDRAM;
                        load_byte(cursor, 1'b0, 1'b0);
                    end
                    FUNC_CLEAR: load_byte(CMD_CLEAR, 1'b0, 1'b1);
                    default: begin
                        pins[4]  = 1'b0;
                        pins[5]  = 1'b0;
                        clr_pend = 1'b0;
                        step     = STEP_FIRST;
                        wait_cnt = cfg.power_up_ticks;
                        ph       = PH_PWR_WAIT;
                    end
                endcase
            end else begin
                dropped = is_req;
                case (ph)
                    PH_PWR_WAIT: if (count_down()) ph = PH_NIB_EN;
                    PH_NIB_EN: begin
                        pins[5]   = 1'b1;
                        pins[3:0] = (step == STEP_LAST_NIB) ? NIB_4BIT : NIB_WAKE;
                        ph        = PH_NIB_FALL;
                    end
                    PH_NIB_FALL, PH_LO_FALL: begin
                        pins[5]  = 1'b0;
                        wait_cnt = cfg.short_delay_ticks;
                        ph       = PH_WAIT_S;
                    end
                    PH_HI_EN: begin
                        pins[5]   = 1'b1;
                        pins[3:0] = hold[7:4];
                        ph        = PH_HI_FALL;
                    end
                    PH_HI_FALL: begin
                        pins[5] = 1'b0;
                        ph      = PH_LO_EN;
                    end
                    PH_LO_EN: begin
                        pins[5]   = 1'b1;
                        pins[3:0] = hold[3:0];
                        ph        = PH_LO_FALL;
                    end
                    PH_WAIT_S: begin
                        if (count_down()) begin
                            if (clr_pend) begin
                                wait_cnt = cfg.long_delay_ticks;
                                ph       = PH_WAIT_L;
                            end else begin
                                next_step();
                            end
                        end
                    end
                    PH_WAIT_L: begin
                        if (count_down()) begin
                            clr_pend = 1'b0;
                            next_step();
                        end
                    end
                    default: ph = PH_IDLE;
                endcase
            end
            want.rs       = pins[4];
            want.en       = pins[5];
            want.nibble   = pins[3:0];
            want.busy_res = (ph != PH_IDLE);
            want.refused  = dropped;
            pin_levels_q.push_back(want);
        endfunction

        function void flag(string what, logic [3:0] want, logic [3:0] got);
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            mismatches++;
        endfunction

        function void check_word(res_t got);
            res_t want;
            if (pin_levels_q.size() == 0) begin
                $display("%0t: result word %h with nothing expected", $time, got);
                mismatches++;
                return;
            end
            want = pin_levels_q.pop_front();
            if (got.rs !== want.rs)
                flag("rs", {3'b000, want.rs}, {3'b000, got.rs});
            if (got.en !== want.en)
                flag("en", {3'b000, want.en}, {3'b000, got.en});
            if (got.nibble !== want.nibble)
                flag("nibble", want.nibble, got.nibble);
            if (got.busy_res !== want.busy_res)
                flag("busy_res", {3'b000, want.busy_res}, {3'b000, got.busy_res});
            if (got.refused !== want.refused)
                flag("refused", {3'b000, want.refused}, {3'b000, got.refused});
        endfunction
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    logic [2:0]          s_func    = '0;
    logic [7:0]          s_value   = '0;
    logic [5:0]          s_col     = '0;
    logic                s_row     = 1'b0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    logic                m_rs;
    logic                m_en;
    logic [3:0]          m_nibble;
    logic                m_busy_res;
    logic                m_refused;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ADDR_W-1:0]   paddr     = '0;
    logic [DATA_W-1:0]   pwdata    = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    lcd_pin_scoreboard sb = new();
    int tx_calm = 0;
    int rx_calm = 0;
    int idle_cycles = 0;

    char_lcd_4bit_interface_unit u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_value    (s_value),
        .s_col      (s_col),
        .s_row      (s_row),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_rs       (m_rs),
        .m_en       (m_en),
        .m_nibble   (m_nibble),
        .m_busy_res (m_busy_res),
        .m_refused  (m_refused),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #1 aclk = ~aclk;

    // mostly short gaps, a few long ones, and now and then a gap-free stretch
    function automatic int pick_gap(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 59) == 0) begin
            calm = $urandom_range(20, 100);
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 97) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    function automatic req_t random_word(logic [2:0] f);
        req_t r;
        r.func  = f;
        r.value = 8'($urandom_range(0, 255));
        r.col   = 6'($urandom_range(0, 63));
        r.row   = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic logic [2:0] filler_func();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85) return FUNC_TICK;
        return (roll < 93) ? FUNC_SPARE_LO : FUNC_SPARE_HI;
    endfunction

    task automatic send_word(req_t r);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_func  <= r.func;
        s_value <= r.value;
        s_col   <= r.col;
        s_row   <= r.row;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(r);
    endtask

    task automatic tick_until_idle();
        while (sb.seq_busy()) send_word(random_word(filler_func()));
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pin_levels_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] v);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, v};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic set_config(logic [15:0] sd, logic [15:0] ld, logic [15:0] pu,
                              logic [7:0] fw, logic [7:0] dw, logic [7:0] ew);
        tick_until_idle();
        drain_results();
        repeat (LATENCY + 2) @(posedge aclk);
        write_reg(REG_SHORT_DELAY, sd);
        write_reg(REG_LONG_DELAY, ld);
        write_reg(REG_POWER_UP, pu);
        write_reg(REG_INIT_FUNC, {8'h00, fw});
        write_reg(REG_INIT_DISP, {8'h00, dw});
        write_reg(REG_INIT_ENTRY, {8'h00, ew});
    endtask

    // well-formed requests when idle, mostly ticks while busy, some refused noise
    task automatic run_random(int n);
        int roll;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 199) == 0) drain_results();
            roll = $urandom_range(0, 99);
            if (!sb.seq_busy()) begin
                if (roll < 85) send_word(random_word(3'($urandom_range(FUNC_CMD, FUNC_INIT))));
                else send_word(random_word(filler_func()));
            end else begin
                if (roll < 92) send_word(random_word(filler_func()));
                else send_word(random_word(3'($urandom_range(FUNC_CMD, FUNC_INIT))));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_word(res_t'({m_rs, m_en, m_nibble, m_busy_res, m_refused}));
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("char_lcd_4bit_interface_unit: mismatch");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : result_side
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = pick_gap(rx_calm);
            if (stall > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin : stimulus
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: idle ticks, byte requests, cursor corner, refused requests
        send_word(req_t'{FUNC_TICK, 8'h00, 6'd0, 1'b0});
        send_word(req_t'{FUNC_SPARE_LO, 8'hFF, 6'd63, 1'b1});
        send_word(req_t'{FUNC_SPARE_HI, 8'h00, 6'd0, 1'b0});
        send_word(req_t'{FUNC_CMD, 8'h00, 6'd0, 1'b0});
        send_word(req_t'{FUNC_DATA, 8'hFF, 6'd63, 1'b1});
        tick_until_idle();
        send_word(req_t'{FUNC_CURSOR, 8'h00, 6'd63, 1'b1});
        send_word(req_t'{FUNC_INIT, 8'h00, 6'd0, 1'b0});
        send_word(req_t'{FUNC_CLEAR, 8'h00, 6'd0, 1'b0});

        // init sequence with short waits, requests refused along the way
        set_config(16'd3, 16'd5, 16'd4, 8'hFF, 8'h00, 8'hA5);
        send_word(req_t'{FUNC_INIT, 8'h00, 6'd0, 1'b0});
        send_word(req_t'{FUNC_CLEAR, 8'h00, 6'd0, 1'b0});
        send_word(req_t'{FUNC_CURSOR, 8'h55, 6'd21, 1'b1});
        send_word(req_t'{FUNC_SPARE_HI, 8'h00, 6'd0, 1'b0});
        tick_until_idle();
        send_word(req_t'{FUNC_CURSOR, 8'hFF, 6'd0, 1'b0});
        tick_until_idle();
        run_random(100);

        // zero delays behave as one tick
        set_config(16'd0, 16'd0, 16'd0, 8'h00, 8'hFF, 8'h00);
        send_word(req_t'{FUNC_INIT, 8'h00, 6'd0, 1'b0});
        tick_until_idle();
        run_random(120);

        set_config(16'd1, 16'd1, 16'd1, 8'hFF, 8'hFF, 8'hFF);
        run_random(120);

        // longer waits after a byte and after a clear
        set_config(16'd40, 16'd90, 16'd1, 8'h28, 8'h0C, 8'h06);
        send_word(req_t'{FUNC_CLEAR, 8'h00, 6'd0, 1'b0});
        tick_until_idle();

        // longer power-up wait
        set_config(16'd1, 16'd1, 16'd120, 8'h28, 8'h0C, 8'h06);
        send_word(req_t'{FUNC_INIT, 8'h00, 6'd0, 1'b0});
        tick_until_idle();

        for (int p = 0; p < 5; p++) begin
            set_config(16'($urandom_range(1, 6)), 16'($urandom_range(1, 10)),
                       16'($urandom_range(1, 8)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            run_random(170);
        end

        drain_results();
        repeat (LATENCY * 4) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pin_levels_q.size() == 0)
            $display("char_lcd_4bit_interface_unit: match");
        else
            $display("char_lcd_4bit_interface_unit: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
rtl/lcd4_pkg.sv
rtl/lcd4_cfg_regs.sv
rtl/lcd4_seq.sv
rtl/char_lcd_4bit_interface_unit.sv
tb/sv/char_lcd_4bit_interface_unit_tb.sv
